### rtl/lps_pkg.sv
// ---------------------------------------------------------------------------
// lps_pkg
// Shared constants and types of the 3x3 Laplacian sharpening block: frame
// limits, register indexes, counter widths and the window/result structs.
// ---------------------------------------------------------------------------
package lps_pkg;

    // Frame limits
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    // Field and register widths
    localparam int PIX_W        = 8;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 1;

    // Counter widths: columns stay below the width, rows run one row past
    // the frame during the drain and saturate at all ones
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT) + 1;
    localparam int EW    = $clog2(MAX_WIDTH + 1);
    localparam int EH    = $clog2(MAX_HEIGHT + 1);

    // Kernel arithmetic: eight neighbours summed, centre times ten
    localparam int CENTRE_WEIGHT = 10;
    localparam int SUM_W         = PIX_W + 3;
    localparam int POS_W         = PIX_W + 4;
    localparam int PIX_MAX       = (1 << PIX_W) - 1;

    // Line store word holds the upper and middle row samples of a column
    localparam int LINE_W = 2 * PIX_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // Register reset values
    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

    // One window column, top row first
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } lps_col_t;

    // Border and position flags of one result
    typedef struct packed {
        logic no_top;
        logic no_bot;
        logic no_left;
        logic no_right;
        logic row_end;
        logic frame_end;
    } lps_flags_t;

    // One result
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             row_end;
        logic             frame_end;
    } lps_result_t;

endpackage

### rtl/lps_line_store.sv
// ---------------------------------------------------------------------------
// lps_line_store
// Two line stores packed in one memory word per column: upper row in the
// high byte, middle row in the low byte. Registered read with write bypass.
// ---------------------------------------------------------------------------
module lps_line_store
    import lps_pkg::*;
(
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [COL_W-1:0]  rd_addr,
    output logic [LINE_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [COL_W-1:0]  wr_addr,
    input  logic [LINE_W-1:0] wr_data
);

    logic [LINE_W-1:0] line_mem_reg [MAX_WIDTH];
    logic [LINE_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port: a write to the same column in this cycle is forwarded
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= line_mem_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/lps_window_cell.sv
// ---------------------------------------------------------------------------
// lps_window_cell
// One column of the 3x3 window. Takes a column from its neighbour on a
// shift and presents its own column to the next cell and the kernel.
// ---------------------------------------------------------------------------
module lps_window_cell
    import lps_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     shift_en,
    input  lps_col_t col_in,
    output lps_col_t col_out
);

    lps_col_t col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (shift_en) begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

### rtl/lps_kernel.sv
// ---------------------------------------------------------------------------
// lps_kernel
// Laplacian sharpening kernel over the three window columns: ten times the
// centre less the neighbours inside the frame, clamped to the pixel range.
// ---------------------------------------------------------------------------
module lps_kernel
    import lps_pkg::*;
(
    input  lps_col_t    left_col,
    input  lps_col_t    centre_col,
    input  lps_col_t    right_col,
    input  lps_flags_t  flags,
    output lps_result_t result
);

    logic [SUM_W-1:0] nb_sum;
    logic [POS_W-1:0] centre_x10;
    logic [POS_W-1:0] diff;
    logic [PIX_W-1:0] pix;

    function automatic logic [SUM_W-1:0] term(input logic [PIX_W-1:0] v, input logic keep);
        term = keep ? SUM_W'(v) : '0;
    endfunction

    // Neighbour sum, zero padding at the frame borders
    always_comb begin
        nb_sum = term(left_col.top,   !flags.no_top && !flags.no_left)
               + term(left_col.mid,   !flags.no_left)
               + term(left_col.bot,   !flags.no_bot && !flags.no_left)
               + term(centre_col.top, !flags.no_top)
               + term(centre_col.bot, !flags.no_bot)
               + term(right_col.top,  !flags.no_top && !flags.no_right)
               + term(right_col.mid,  !flags.no_right)
               + term(right_col.bot,  !flags.no_bot && !flags.no_right);
    end

    // Weighted centre less neighbours, clamped
    always_comb begin
        centre_x10 = POS_W'(centre_col.mid) * POS_W'(CENTRE_WEIGHT);
        diff       = centre_x10 - POS_W'(nb_sum);
        if (POS_W'(nb_sum) > centre_x10) begin
            pix = '0;
        end else if (diff > POS_W'(PIX_MAX)) begin
            pix = PIX_W'(PIX_MAX);
        end else begin
            pix = diff[PIX_W-1:0];
        end
    end

    assign result.pix       = pix;
    assign result.row_end   = flags.row_end;
    assign result.frame_end = flags.frame_end;

endmodule

### rtl/laplacian_sharpen_3x3.sv
// Path: the item that completes a window (one row plus one pixel after its
// own) is registered in the line store, window and output stages in turn.
// Throughput: 1 item per cycle, set by the separate line store read and write
// ports and the one-column shift of the window cell chain; input stalls only
// while the skid register holds a result. Reset: clears counters, window and
// handshake state; width 640, height 480; the line store is not cleared.
// ---------------------------------------------------------------------------
// laplacian_sharpen_3x3
// Streaming 3x3 Laplacian sharpening of one 8-bit channel. Position control
// at the input, line store read, window cell chain, kernel, skid output.
// ---------------------------------------------------------------------------
module laplacian_sharpen_3x3
    import lps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic [PIX_W-1:0]      s_sample,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIX_W-1:0]      m_sharpened,
    output logic                  m_row_end,
    output logic                  m_frame_end
);

    // Configuration
    logic [WIDTH_REG_W-1:0]  image_width_reg;
    logic [HEIGHT_REG_W-1:0] image_height_reg;
    logic [EW-1:0]           w_eff;
    logic [EH-1:0]           h_eff;

    // Position counters
    logic [COL_W-1:0] in_col_reg,  in_col_next;
    logic [ROW_W-1:0] in_row_reg,  in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;

    // Input side decode
    logic             pipe_en;
    logic             in_xfer;
    logic             drain_idle;
    logic             take;
    logic [PIX_W-1:0] s_eff;
    logic             emit;
    lps_flags_t       flags;

    // Line store stage
    logic             b_vld_reg;
    logic [COL_W-1:0] b_col_reg;
    logic [PIX_W-1:0] b_sample_reg;
    logic             b_emit_reg;
    lps_flags_t       b_flags_reg;
    logic [LINE_W-1:0] ls_rd_data;
    logic              ls_wr_en;

    // Window stage
    logic        c_vld_reg;
    lps_flags_t  c_flags_reg;
    lps_col_t    new_col;
    lps_col_t    win [3];
    lps_col_t    cell_in [3];
    lps_result_t k_res;

    // Output register and skid
    logic        m_valid_reg;
    lps_result_t m_data_reg;
    logic        skid_valid_reg;
    lps_result_t skid_data_reg;
    logic        push;
    logic        pop;

    function automatic logic [ROW_W-1:0] sat_inc(input logic [ROW_W-1:0] v);
        sat_inc = (v == '1) ? v : v + ROW_W'(1);
    endfunction

    // Effective frame size: zero reads as one, large values saturate
    always_comb begin
        if (image_width_reg == '0) begin
            w_eff = EW'(1);
        end else if (32'(image_width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = EW'(image_width_reg);
        end
        if (image_height_reg == '0) begin
            h_eff = EH'(1);
        end else if (32'(image_height_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = EH'(MAX_HEIGHT);
        end else begin
            h_eff = EH'(image_height_reg);
        end
    end

    // Input transfer decode and position update
    always_comb begin
        pipe_en    = !skid_valid_reg;
        in_xfer    = s_valid && pipe_en;
        drain_idle = s_op && (in_row_reg == '0) && (in_col_reg == '0);
        take       = in_xfer && !drain_idle;

        // drain ticks and pixels past the last row enter as zero
        s_eff = (s_op || (32'(in_row_reg) >= 32'(h_eff))) ? '0 : s_sample;
        emit  = (32'(in_row_reg) >= 32'd2)
              || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));

        flags.no_top    = (out_row_reg == '0);
        flags.no_bot    = (32'(out_row_reg) + 32'd1 >= 32'(h_eff));
        flags.no_left   = (out_col_reg == '0);
        flags.no_right  = (32'(out_col_reg) + 32'd1 >= 32'(w_eff));
        flags.row_end   = flags.no_right;
        flags.frame_end = flags.no_right && flags.no_bot;

        if (32'(in_col_reg) + 32'd1 >= 32'(w_eff)) begin
            in_col_next = '0;
            in_row_next = sat_inc(in_row_reg);
        end else begin
            in_col_next = in_col_reg + COL_W'(1);
            in_row_next = in_row_reg;
        end
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if (emit) begin
            if (flags.frame_end) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end else if (flags.row_end) begin
                out_col_next = '0;
                out_row_next = sat_inc(out_row_reg);
            end else begin
                out_col_next = out_col_reg + COL_W'(1);
            end
        end
    end

    // Configuration registers and position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_IMAGE_WIDTH: begin
                        image_width_reg <= cfg_wdata[WIDTH_REG_W-1:0];
                    end
                    REG_IMAGE_HEIGHT: begin
                        image_height_reg <= cfg_wdata[HEIGHT_REG_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (take) begin
                in_col_reg  <= in_col_next;
                in_row_reg  <= in_row_next;
                out_col_reg <= out_col_next;
                out_row_reg <= out_row_next;
            end
        end
    end

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            b_vld_reg <= take;
            c_vld_reg <= b_vld_reg && b_emit_reg;
        end
    end

    // Stage payload
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            b_col_reg    <= in_col_reg;
            b_sample_reg <= s_eff;
            b_emit_reg   <= emit;
            b_flags_reg  <= flags;
            c_flags_reg  <= b_flags_reg;
        end
    end

    // Line stores: read at the transfer, shift down when the line store stage advances
    assign ls_wr_en = pipe_en && b_vld_reg;

    lps_line_store u_line_store (
        .aclk    (aclk),
        .rd_en   (take),
        .rd_addr (in_col_reg),
        .rd_data (ls_rd_data),
        .wr_en   (ls_wr_en),
        .wr_addr (b_col_reg),
        .wr_data ({ls_rd_data[PIX_W-1:0], b_sample_reg})
    );

    // Window cell chain: newest column enters cell 2
    assign new_col.top = ls_rd_data[LINE_W-1:PIX_W];
    assign new_col.mid = ls_rd_data[PIX_W-1:0];
    assign new_col.bot = b_sample_reg;

    for (genvar i = 0; i < 3; i++) begin : g_cell
        if (i == 2) begin : g_head
            assign cell_in[i] = new_col;
        end else begin : g_link
            assign cell_in[i] = win[i+1];
        end
        lps_window_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (ls_wr_en),
            .col_in   (cell_in[i]),
            .col_out  (win[i])
        );
    end

    lps_kernel u_kernel (
        .left_col   (win[0]),
        .centre_col (win[1]),
        .right_col  (win[2]),
        .flags      (c_flags_reg),
        .result     (k_res)
    );

    // Output register with skid stage
    assign push = pipe_en && c_vld_reg;
    assign pop  = m_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                m_data_reg     <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!m_valid_reg || pop) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= k_res;
            end else begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= k_res;
            end
        end else if (pop) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign s_ready     = pipe_en;
    assign m_valid     = m_valid_reg;
    assign m_sharpened = m_data_reg.pix;
    assign m_row_end   = m_data_reg.row_end;
    assign m_frame_end = m_data_reg.frame_end;

endmodule

### rtl/lps_checker.sv
// ---------------------------------------------------------------------------
// lps_checker
// Port-level checks of the sharpening block: result hold under stall, reset
// state, flag consistency and input back-pressure only behind a result.
// ---------------------------------------------------------------------------
module lps_checker
    import lps_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [PIX_W-1:0]      m_sharpened,
    input logic                  m_row_end,
    input logic                  m_frame_end
);

    // A stalled result holds until its transfer
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sharpened)
            && $stable(m_row_end) && $stable(m_frame_end))
        else $error("stalled result changed");

    // No result straight out of reset
    a_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid after reset");

    // The last result of a frame also ends its row
    a_frame_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_row_end)
        else $error("frame end without row end");

    // Input back-pressure only while a result waits
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

endmodule

bind laplacian_sharpen_3x3 lps_checker u_lps_checker (.*);
